### hw/rtl/mbps_pkg.sv
package mbps_pkg;

	// field widths
	localparam int STEP_W = 4;
	localparam int SEC_W = 16;
	localparam int TGT_W = 14;
	localparam int DUTY_W = 7;
	localparam int MIN_W = 8;
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int DROP_W = 4;
	localparam int REM_W = 16;
	localparam int HOPPERS_DEF = 4;

	// request opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MASH_TARGET = 3'd0;
	localparam logic [IDX_W-1:0] REG_MASH_DUTY = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOIL_DUTY = 3'd2;
	localparam logic [IDX_W-1:0] REG_MASH_MIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRAIN_MIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_BOIL_MIN = 3'd5;
	localparam logic [IDX_W-1:0] REG_HOP_MIN = 3'd6;

	// configuration reset values
	localparam logic [TGT_W-1:0] RST_MASH_TARGET = 14'd6600;
	localparam logic [DUTY_W-1:0] RST_MASH_DUTY = 7'd50;
	localparam logic [DUTY_W-1:0] RST_BOIL_DUTY = 7'd100;
	localparam logic [MIN_W-1:0] RST_MASH_MIN = 8'd60;
	localparam logic [MIN_W-1:0] RST_DRAIN_MIN = 8'd10;
	localparam logic [MIN_W-1:0] RST_BOIL_MIN = 8'd60;
	localparam logic [CFG_W-1:0] RST_HOP_MIN = 32'd0;

	// process constants (temperatures in 0.01 degree)
	localparam logic [TGT_W-1:0] TGT_MASH_OUT = 14'd7500;
	localparam logic [TGT_W-1:0] TGT_TO_BOIL = 14'd9200;
	localparam logic [TGT_W-1:0] TGT_BOIL = 14'd10100;
	localparam logic [TGT_W-1:0] STRIKE_OFFSET = 14'd500;
	localparam logic [TGT_W-1:0] VALVE_CLOSE_SEC = 14'd600;
	localparam logic [SEC_W-1:0] STIR_SEC = 16'd60;
	localparam logic [DUTY_W-1:0] FILL_DUTY = 7'd90;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

	typedef enum logic [STEP_W-1:0] {
		ST_FILL,
		ST_MASH_IN,
		ST_STIR,
		ST_MASH,
		ST_MASH_OUT,
		ST_DRAIN,
		ST_TO_BOIL,
		ST_BOIL,
		ST_FINISH
	} step_t;

	typedef struct packed {
		logic [TGT_W-1:0] mash_target;
		logic [DUTY_W-1:0] mash_duty;
		logic [DUTY_W-1:0] boil_duty;
		logic [MIN_W-1:0] mash_min;
		logic [MIN_W-1:0] drain_min;
		logic [MIN_W-1:0] boil_min;
		logic [CFG_W-1:0] hop_min;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [STEP_W-1:0] start_step;
		logic second_pulse;
		logic heat_at_target;
		logic level_high;
		logic level_low;
	} item_t;

	typedef struct packed {
		step_t step;
		logic [SEC_W-1:0] sec;
		logic draining;
		logic pump;
		logic stir;
		logic valve;
		logic heat;
		logic [TGT_W-1:0] tgt;
		logic [DUTY_W-1:0] duty;
		logic run;
	} ctrl_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_now;
		logic step_entered;
		logic pump_on;
		logic stirrer_on;
		logic valve_open;
		logic heater_on;
		logic [TGT_W-1:0] heat_target;
		logic [DUTY_W-1:0] heat_duty;
		logic [DROP_W-1:0] hop_drop;
		logic [SEC_W-1:0] seconds_in_step;
		logic signed [REM_W-1:0] seconds_remaining;
	} res_t;

	// minutes to seconds: m*64 - m*4
	function automatic logic [TGT_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
		logic [TGT_W-1:0] mw;
		mw = TGT_W'(m);
		return (mw << 6) - (mw << 2);
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
		return (d > DUTY_MAX) ? DUTY_MAX : d;
	endfunction

endpackage

### hw/rtl/mbps_in_if.sv
interface mbps_in_if;
	import mbps_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] op;
	logic [STEP_W-1:0] start_step;
	logic second_pulse;
	logic heat_at_target;
	logic level_high;
	logic level_low;

	modport source (
		output valid, op, start_step, second_pulse, heat_at_target, level_high, level_low,
		input ready
	);
	modport sink (
		input valid, op, start_step, second_pulse, heat_at_target, level_high, level_low,
		output ready
	);
endinterface

### hw/rtl/mbps_out_if.sv
interface mbps_out_if;
	import mbps_pkg::*;

	logic valid;
	logic ready;
	logic [STEP_W-1:0] step_now;
	logic step_entered;
	logic pump_on;
	logic stirrer_on;
	logic valve_open;
	logic heater_on;
	logic [TGT_W-1:0] heat_target;
	logic [DUTY_W-1:0] heat_duty;
	logic [DROP_W-1:0] hop_drop;
	logic [SEC_W-1:0] seconds_in_step;
	logic signed [REM_W-1:0] seconds_remaining;

	modport source (
		output valid, step_now, step_entered, pump_on, stirrer_on, valve_open, heater_on,
		heat_target, heat_duty, hop_drop, seconds_in_step, seconds_remaining,
		input ready
	);
	modport sink (
		input valid, step_now, step_entered, pump_on, stirrer_on, valve_open, heater_on,
		heat_target, heat_duty, hop_drop, seconds_in_step, seconds_remaining,
		output ready
	);
endinterface

### hw/rtl/mbps_next.sv
module mbps_next import mbps_pkg::*; #(
	parameter int HOPPERS = HOPPERS_DEF
) (
	input ctrl_t cur,
	input logic [HOPPERS-1:0] hop_cur,
	input cfg_t cfg,
	input item_t item,
	output ctrl_t nxt,
	output logic [HOPPERS-1:0] hop_nxt,
	output res_t res
);

	logic [SEC_W-1:0] sec_t;
	logic signed [SEC_W:0] rem_boil;
	logic [TGT_W-1:0] strike;
	logic [HOPPERS-1:0] hop_hit;
	logic [HOPPERS-1:0] drop_v;
	logic [HOPPERS+DROP_W-1:0] drop_ext;
	logic do_enter;
	step_t enter_s;
	logic go;
	logic entered;
	logic [TGT_W-1:0] rem_base;
	logic signed [SEC_W:0] rem_o;

	// tick seconds count, saturating
	assign sec_t = (item.second_pulse && cur.sec != '1) ? cur.sec + 1'b1 : cur.sec;

	// boil remaining time against the counted seconds
	assign rem_boil = signed'({3'b000, min_to_sec(cfg.boil_min)}) - signed'({1'b0, sec_t});

	assign strike = (cfg.mash_target >= STRIKE_OFFSET) ? cfg.mash_target - STRIKE_OFFSET : '0;

	// per-hopper drop threshold; hoppers past the packed bytes drop at zero
	for (genvar i = 0; i < HOPPERS; i++) begin : g_hop
		logic [TGT_W-1:0] thr;
		if (i < 4) begin : g_byte
			assign thr = min_to_sec(cfg.hop_min[8*i +: 8]);
		end else begin : g_zero
			assign thr = '0;
		end
		assign hop_hit[i] = rem_boil <= signed'({3'b000, thr});
	end

	// next state
	always_comb begin
		nxt = cur;
		hop_nxt = hop_cur;
		drop_v = '0;
		do_enter = 1'b0;
		enter_s = ST_FILL;
		go = 1'b0;
		entered = 1'b0;
		case (item.op)
			OP_START: begin
				nxt.run = 1'b1;
				do_enter = 1'b1;
				enter_s = (item.start_step > STEP_W'(ST_FINISH)) ? ST_FINISH :
					step_t'(item.start_step);
			end
			OP_STOP: begin
				nxt.run = 1'b0;
				nxt.pump = 1'b0;
				nxt.stir = 1'b0;
				nxt.valve = 1'b0;
				nxt.heat = 1'b0;
			end
			OP_TICK: begin
				if (cur.run) begin
					nxt.sec = sec_t;
					case (cur.step)
						ST_FILL: go = item.heat_at_target;
						ST_MASH_IN: begin
							nxt.tgt = cfg.mash_target;
							nxt.duty = clamp_duty(cfg.mash_duty);
							go = item.level_high;
						end
						ST_STIR: begin
							nxt.tgt = cfg.mash_target;
							nxt.duty = clamp_duty(cfg.mash_duty);
							go = sec_t > STIR_SEC;
						end
						ST_MASH: begin
							// fill until high probe wets, drain until low probe dries
							if (cur.draining) begin
								if (!item.level_low) begin
									nxt.draining = 1'b0;
									nxt.valve = 1'b0;
								end
							end else if (item.level_high) begin
								nxt.draining = 1'b1;
								nxt.valve = 1'b1;
							end
							nxt.tgt = cfg.mash_target;
							nxt.duty = clamp_duty(cfg.mash_duty);
							go = sec_t > SEC_W'(min_to_sec(cfg.mash_min));
						end
						ST_MASH_OUT: begin
							nxt.pump = 1'b1;
							nxt.valve = 1'b1;
							go = item.heat_at_target;
						end
						ST_DRAIN: go = sec_t > SEC_W'(min_to_sec(cfg.drain_min));
						ST_TO_BOIL: begin
							nxt.pump = 1'b0;
							nxt.valve = 1'b1;
							go = item.heat_at_target;
						end
						ST_BOIL: begin
							nxt.heat = 1'b1;
							nxt.tgt = TGT_BOIL;
							nxt.duty = clamp_duty(cfg.boil_duty);
							for (int i = 0; i < HOPPERS; i++) begin
								if (!hop_cur[i] && hop_hit[i]) begin
									hop_nxt[i] = 1'b1;
									drop_v[i] = 1'b1;
								end
							end
							if (rem_boil < signed'({3'b000, VALVE_CLOSE_SEC}))
								nxt.valve = 1'b0;
							go = rem_boil <= 0;
						end
						default: go = 1'b0;
					endcase
					if (go && cur.step != ST_FINISH) begin
						nxt.stir = 1'b0;
						do_enter = 1'b1;
						enter_s = step_t'(STEP_W'(cur.step) + 4'd1);
					end
				end
			end
			default: ;
		endcase

		// step entry settings
		if (do_enter) begin
			entered = 1'b1;
			nxt.step = enter_s;
			nxt.sec = '0;
			case (enter_s)
				ST_FILL: begin
					nxt.heat = 1'b1;
					nxt.tgt = strike;
					nxt.duty = FILL_DUTY;
				end
				ST_MASH_IN, ST_STIR: begin
					nxt.stir = (enter_s == ST_STIR);
					nxt.pump = (enter_s == ST_MASH_IN);
					nxt.valve = 1'b0;
					nxt.heat = 1'b1;
					nxt.tgt = cfg.mash_target;
					nxt.duty = clamp_duty(cfg.mash_duty);
				end
				ST_MASH: begin
					nxt.draining = 1'b0;
					nxt.stir = 1'b0;
					nxt.pump = 1'b1;
					nxt.valve = 1'b0;
					nxt.heat = 1'b1;
					nxt.tgt = cfg.mash_target;
					nxt.duty = clamp_duty(cfg.mash_duty);
				end
				ST_MASH_OUT: begin
					nxt.heat = 1'b1;
					nxt.tgt = TGT_MASH_OUT;
					nxt.duty = clamp_duty(cfg.boil_duty);
					nxt.pump = 1'b1;
					nxt.valve = 1'b1;
				end
				ST_DRAIN: begin
					nxt.pump = 1'b0;
					nxt.valve = 1'b1;
					nxt.heat = 1'b1;
					nxt.tgt = TGT_MASH_OUT;
					nxt.duty = clamp_duty(cfg.boil_duty);
				end
				ST_TO_BOIL: begin
					nxt.pump = 1'b0;
					nxt.valve = 1'b1;
					nxt.heat = 1'b1;
					nxt.tgt = TGT_TO_BOIL;
					nxt.duty = clamp_duty(cfg.boil_duty);
				end
				ST_BOIL: begin
					nxt.heat = 1'b1;
					nxt.tgt = TGT_BOIL;
					nxt.duty = clamp_duty(cfg.boil_duty);
					hop_nxt = '0;
					// seconds are zero on entry, so remaining is the full boil
					if (min_to_sec(cfg.boil_min) < VALVE_CLOSE_SEC)
						nxt.valve = 1'b0;
				end
				default: nxt.heat = 1'b0;
			endcase
		end
	end

	assign drop_ext = {{DROP_W{1'b0}}, drop_v};

	// remaining time of the timed steps
	always_comb begin
		case (nxt.step)
			ST_MASH: rem_base = min_to_sec(cfg.mash_min);
			ST_DRAIN: rem_base = min_to_sec(cfg.drain_min);
			ST_BOIL: rem_base = min_to_sec(cfg.boil_min);
			default: rem_base = '0;
		endcase
		if (nxt.step == ST_MASH || nxt.step == ST_DRAIN || nxt.step == ST_BOIL)
			rem_o = signed'({3'b000, rem_base}) - signed'({1'b0, nxt.sec});
		else
			rem_o = '0;
	end

	// result
	always_comb begin
		res.step_now = STEP_W'(nxt.step);
		res.step_entered = entered;
		res.pump_on = nxt.pump;
		res.stirrer_on = nxt.stir;
		res.valve_open = nxt.valve;
		res.heater_on = nxt.heat;
		res.heat_target = nxt.tgt;
		res.heat_duty = nxt.duty;
		res.hop_drop = drop_ext[DROP_W-1:0];
		res.seconds_in_step = nxt.sec;
		// only the low side can overflow 16 bits
		res.seconds_remaining = (rem_o[SEC_W:SEC_W-1] == 2'b10) ?
			{1'b1, {(REM_W-1){1'b0}}} : rem_o[REM_W-1:0];
	end

endmodule

### hw/rtl/mash_boil_process_sequencer_unit.sv
// Mash and boil process sequencer. Each request (tick, start at a step, or stop) yields
// exactly one result with the step, drive outputs, heater target and duty, hopper drop
// pulses and step timing. One request is taken every clock cycle while request ready is
// high; a request is held in the input register, then its result is loaded into the
// result register, which presents it. The next-state logic between those registers is
// combinational; request ready falls only while a result is held and not taken. The user
// must write the configuration registers through cfg_we, cfg_idx and cfg_data while the
// block is idle; the block does not enforce this. Writes to unused indexes are ignored.
module mash_boil_process_sequencer_unit import mbps_pkg::*; #(
	parameter int HOPPERS = HOPPERS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0] cfg_data,
	mbps_in_if.sink request,
	mbps_out_if.source result
);

	cfg_t cfg_q;
	item_t item_s1;
	logic v_s1;
	ctrl_t ctrl_q;
	logic [HOPPERS-1:0] hop_q;
	res_t res_q;
	logic res_v_q;

	ctrl_t ctrl_nxt;
	logic [HOPPERS-1:0] hop_nxt;
	res_t res_nxt;
	logic fire;
	logic take;

	// stage 1 moves on when the result register is free or being emptied
	assign fire = v_s1 && (!res_v_q || result.ready);
	assign request.ready = !v_s1 || fire;
	assign take = request.valid && request.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mash_target <= RST_MASH_TARGET;
			cfg_q.mash_duty <= RST_MASH_DUTY;
			cfg_q.boil_duty <= RST_BOIL_DUTY;
			cfg_q.mash_min <= RST_MASH_MIN;
			cfg_q.drain_min <= RST_DRAIN_MIN;
			cfg_q.boil_min <= RST_BOIL_MIN;
			cfg_q.hop_min <= RST_HOP_MIN;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MASH_TARGET: cfg_q.mash_target <= cfg_data[TGT_W-1:0];
				REG_MASH_DUTY: cfg_q.mash_duty <= cfg_data[DUTY_W-1:0];
				REG_BOIL_DUTY: cfg_q.boil_duty <= cfg_data[DUTY_W-1:0];
				REG_MASH_MIN: cfg_q.mash_min <= cfg_data[MIN_W-1:0];
				REG_DRAIN_MIN: cfg_q.drain_min <= cfg_data[MIN_W-1:0];
				REG_BOIL_MIN: cfg_q.boil_min <= cfg_data[MIN_W-1:0];
				REG_HOP_MIN: cfg_q.hop_min <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (take)
			v_s1 <= 1'b1;
		else if (fire)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op <= request.op;
			item_s1.start_step <= request.start_step;
			item_s1.second_pulse <= request.second_pulse;
			item_s1.heat_at_target <= request.heat_at_target;
			item_s1.level_high <= request.level_high;
			item_s1.level_low <= request.level_low;
		end
	end

	mbps_next #(
		.HOPPERS(HOPPERS)
	) u_next (
		.cur(ctrl_q),
		.hop_cur(hop_q),
		.cfg(cfg_q),
		.item(item_s1),
		.nxt(ctrl_nxt),
		.hop_nxt(hop_nxt),
		.res(res_nxt)
	);

	// process state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			hop_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (fire) begin
				ctrl_q <= ctrl_nxt;
				hop_q <= hop_nxt;
			end
			if (fire)
				res_v_q <= 1'b1;
			else if (result.ready)
				res_v_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_nxt;
	end

	assign result.valid = res_v_q;
	assign result.step_now = res_q.step_now;
	assign result.step_entered = res_q.step_entered;
	assign result.pump_on = res_q.pump_on;
	assign result.stirrer_on = res_q.stirrer_on;
	assign result.valve_open = res_q.valve_open;
	assign result.heater_on = res_q.heater_on;
	assign result.heat_target = res_q.heat_target;
	assign result.heat_duty = res_q.heat_duty;
	assign result.hop_drop = res_q.hop_drop;
	assign result.seconds_in_step = res_q.seconds_in_step;
	assign result.seconds_remaining = res_q.seconds_remaining;

endmodule

### hw/rtl/mbps_checker.sv
module mbps_checker import mbps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [STEP_W-1:0] step_now,
	input logic step_entered,
	input logic [DROP_W-1:0] hop_drop,
	input logic [SEC_W-1:0] seconds_in_step,
	input logic signed [REM_W-1:0] seconds_remaining
);

	// a held result is not withdrawn
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// entering a step restarts its seconds
	a_enter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_entered |-> seconds_in_step == '0)
		else $error("step entered with nonzero seconds");

	// hoppers drop only in the boil, or on the tick that ends it
	a_drop_boil: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hop_drop != '0 |->
			step_now == STEP_W'(ST_BOIL) || step_now == STEP_W'(ST_FINISH))
		else $error("hopper drop outside boil");

	// untimed steps report no remaining time
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_now != STEP_W'(ST_MASH) && step_now != STEP_W'(ST_DRAIN) &&
			step_now != STEP_W'(ST_BOIL) |-> seconds_remaining == '0)
		else $error("remaining time in untimed step");

endmodule

bind mash_boil_process_sequencer_unit mbps_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.step_now(result.step_now),
	.step_entered(result.step_entered),
	.hop_drop(result.hop_drop),
	.seconds_in_step(result.seconds_in_step),
	.seconds_remaining(result.seconds_remaining)
);
